@@ src/vtpc_pkg.sv @@
// shared types and codes for the virtual texture page cache
package vtpc_pkg;

    typedef logic [43:0] page_key_t;

    typedef struct packed {
        logic       valid;
        page_key_t  key;
        logic [31:0] used;
    } res_entry_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_SWAP_EVEN,
        OP_SWAP_ODD,
        OP_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        res_entry_t wdata;
    } res_ctl_t;

    typedef struct packed {
        cell_op_t   op;
        page_key_t  wkey;
    } pend_ctl_t;

    localparam logic [1:0] REQ_FEEDBACK = 2'd0;
    localparam logic [1:0] REQ_PAGE     = 2'd1;
    localparam logic [1:0] REQ_FRAME    = 2'd2;
    localparam logic [1:0] REQ_EVICT    = 2'd3;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_PENDING = 3'd1;
    localparam logic [2:0] ST_QUEUED  = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    localparam logic REG_MAX_PAGES    = 1'b0;
    localparam logic REG_STALE_WINDOW = 1'b1;

endpackage

@@ src/vtpc_res_cell.sv @@
// one resident page slot of the rotating page chain
module vtpc_res_cell #(
    parameter int IDX  = 0,
    parameter int NUM  = 256,
    parameter int IDXW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vtpc_pkg::res_ctl_t   ctl,
    input  logic [IDXW-1:0]      wr_idx,
    input  vtpc_pkg::res_entry_t left,
    input  vtpc_pkg::res_entry_t right,
    output vtpc_pkg::res_entry_t q
);
    import vtpc_pkg::*;

    localparam bit HAS_LEFT  = (IDX > 0);
    localparam bit HAS_RIGHT = (IDX < NUM - 1);
    localparam bit EVEN_IDX  = ((IDX % 2) == 0);

    logic        valid_reg;
    page_key_t   key_reg;
    logic [31:0] used_reg;
    res_entry_t  cell_next;
    logic        is_left;

    assign q = {valid_reg, key_reg, used_reg};

    always_comb
    begin
        is_left   = EVEN_IDX ^ (ctl.op == OP_SWAP_ODD);
        cell_next = q;
        case (ctl.op)
            OP_SHIFT:
            begin
                cell_next = right;
            end
            OP_SWAP_EVEN, OP_SWAP_ODD:
            begin
                // invalid slots bubble up, valid ones keep their order
                if (is_left && HAS_RIGHT && !valid_reg && right.valid)
                begin
                    cell_next = right;
                end
                else if (!is_left && HAS_LEFT && !left.valid && valid_reg)
                begin
                    cell_next = left;
                end
            end
            OP_WRITE:
            begin
                if (wr_idx == IDXW'(IDX))
                begin
                    cell_next = ctl.wdata;
                end
            end
            default:
            begin
                cell_next = q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= cell_next.key;
        used_reg <= cell_next.used;
    end

endmodule

@@ src/vtpc_pend_cell.sv @@
// one slot of the rotating pending key chain
module vtpc_pend_cell #(
    parameter int IDX  = 0,
    parameter int IDXW = 5
) (
    input  logic                clk,
    input  vtpc_pkg::pend_ctl_t ctl,
    input  logic [IDXW-1:0]     wr_idx,
    input  vtpc_pkg::page_key_t right,
    output vtpc_pkg::page_key_t q
);
    import vtpc_pkg::*;

    page_key_t key_reg;
    page_key_t key_next;

    assign q = key_reg;

    always_comb
    begin
        key_next = key_reg;
        case (ctl.op)
            OP_SHIFT:
            begin
                key_next = right;
            end
            OP_WRITE:
            begin
                if (wr_idx == IDXW'(IDX))
                begin
                    key_next = ctl.wkey;
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

@@ src/virtual_texture_page_cache_top.sv @@
// virtual texture page cache: rotating page chain, pending chain and control
//
//  channel  | direction | payload
//  s_*      | in        | tuser: req_type; tdata: texture_id..keep_frames
//  m_*      | out       | tuser: status; tdata: evicted/resident/pending counts
//  apb      | in        | max_pages at 0x0, stale_window at 0x4
//
// feedback and request items take one full turn of the page chain past the compare
// tap at slot 0; end of frame takes one promotion pass over the pending chain
// without eviction; an age-only eviction adds an age pass and compaction, and a
// capacity eviction adds an age pass, up to 33 count passes, a drop pass and
// compaction
// reset clears all slot valid bits at once; no clearing pass is needed
// one item at a time; a finished result waits in the output register while
// the next item is accepted, and the block stalls only at its own result
module virtual_texture_page_cache_top #(
    parameter int CACHE_SLOTS   = 256,
    parameter int PENDING_SLOTS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // texture_id[15:0] mip_level[19:16] tile_x[31:20] tile_y[43:32]
    // frame[75:44] keep_frames[107:76] zero[111:108]
    input  logic [111:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // evicted_count[8:0] resident_count[17:9] pending_count[23:18]
    output logic [23:0]   m_tdata,
    // status[2:0]
    output logic [2:0]    m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import vtpc_pkg::*;

    localparam int RIDXW    = $clog2(CACHE_SLOTS);
    localparam int RCW      = $clog2(CACHE_SLOTS + 1);
    localparam int PIDXW    = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int PCW      = $clog2(PENDING_SLOTS + 1);
    localparam int LOOK_LEN = (CACHE_SLOTS > PENDING_SLOTS) ? CACHE_SLOTS : PENDING_SLOTS;
    localparam int CW       = $clog2(LOOK_LEN);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_LOOK    = 13'b0000000000010,
        S_ENQ     = 13'b0000000000100,
        S_PROMO   = 13'b0000000001000,
        S_CHECK   = 13'b0000000010000,
        S_AGE     = 13'b0000000100000,
        S_EXCESS  = 13'b0000001000000,
        S_SETUP   = 13'b0000010000000,
        S_COUNT   = 13'b0000100000000,
        S_CNTDONE = 13'b0001000000000,
        S_DROP    = 13'b0010000000000,
        S_COMPACT = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } state_t;

    function automatic logic [31:0] thr_of(input logic [31:0] f, input logic [31:0] w);
        return (f > w) ? (f - w) : 32'd0;
    endfunction

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [1:0]        type_reg, type_next;
    page_key_t         key_reg, key_next;
    logic [31:0]       frame_reg, frame_next;
    logic [31:0]       thr_reg, thr_next;
    logic              hit_reg, hit_next;
    logic              pfound_reg, pfound_next;
    logic [2:0]        status_reg, status_next;
    logic [RCW-1:0]    ev_reg, ev_next;
    logic [RCW-1:0]    res_tot_reg, res_tot_next;
    logic [PCW-1:0]    pend_tot_reg, pend_tot_next;
    logic [RCW-1:0]    excess_reg, excess_next;
    logic [31:0]       ans_reg, ans_next;
    logic [31:0]       t_reg, t_next;
    logic [4:0]        bit_reg, bit_next;
    logic              lt_mode_reg, lt_mode_next;
    logic [RCW-1:0]    cntc_reg, cntc_next;
    logic [RCW-1:0]    quota_reg, quota_next;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic [2:0]        m_tuser_reg;
    logic [7:0]        max_pages_reg;
    logic [31:0]       stale_window_reg;

    res_entry_t        res_q [CACHE_SLOTS];
    page_key_t         pend_q [PENDING_SLOTS];
    res_entry_t        tap, res_loop;
    page_key_t         ptap;
    res_ctl_t          res_ctl;
    pend_ctl_t         pend_ctl;

    logic              look_res, look_pend, res_match, pend_match;
    logic              rm_age, rm_lt, rm_eq, cnt_hit, promo_wr, enq_wr, can_out;
    logic              last_look, last_res, last_pend;
    logic [RCW-1:0]    cap;
    logic [31:0]       ans_try;
    logic [15:0]       ev_w, res_w, pend_w;
    logic              cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_STALE_WINDOW) ? stale_window_reg
                                                    : {24'd0, max_pages_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pages_reg    <= 8'd224;
            stale_window_reg <= 32'd60;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_PAGES)
            begin
                max_pages_reg <= pwdata[7:0];
            end
            else
            begin
                stale_window_reg <= pwdata;
            end
        end
    end

    // resident page chain, slot 0 is the compare tap
    genvar gi;
    generate
        for (gi = 0; gi < CACHE_SLOTS; gi++)
        begin : g_res
            res_entry_t lft, rgt;
            if (gi == 0)
            begin : g_first
                assign lft = '0;
            end
            else
            begin : g_mid_l
                assign lft = res_q[gi-1];
            end
            if (gi == CACHE_SLOTS - 1)
            begin : g_last
                assign rgt = res_loop;
            end
            else
            begin : g_mid_r
                assign rgt = res_q[gi+1];
            end
            vtpc_res_cell #(
                .IDX  (gi),
                .NUM  (CACHE_SLOTS),
                .IDXW (RIDXW)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (res_ctl),
                .wr_idx (res_tot_reg[RIDXW-1:0]),
                .left   (lft),
                .right  (rgt),
                .q      (res_q[gi])
            );
        end

        for (gi = 0; gi < PENDING_SLOTS; gi++)
        begin : g_pend
            page_key_t prgt;
            if (gi == PENDING_SLOTS - 1)
            begin : g_last
                assign prgt = pend_q[0];
            end
            else
            begin : g_mid
                assign prgt = pend_q[gi+1];
            end
            vtpc_pend_cell #(
                .IDX  (gi),
                .IDXW (PIDXW)
            ) u_cell (
                .clk    (clk),
                .ctl    (pend_ctl),
                .wr_idx (pend_tot_reg[PIDXW-1:0]),
                .right  (prgt),
                .q      (pend_q[gi])
            );
        end
    endgenerate

    assign tap  = res_q[0];
    assign ptap = pend_q[0];

    always_comb
    begin
        look_res   = ({1'b0, cnt_reg} < (CW+1)'(CACHE_SLOTS));
        look_pend  = ({1'b0, cnt_reg} < (CW+1)'(PENDING_SLOTS));
        res_match  = tap.valid && (tap.key == key_reg);
        pend_match = (16'(cnt_reg) < 16'(pend_tot_reg)) && (ptap == key_reg);
        rm_age     = tap.valid && (tap.used < thr_reg);
        rm_lt      = tap.valid && (tap.used < ans_reg);
        rm_eq      = tap.valid && (tap.used == ans_reg) && (quota_reg != '0);
        cnt_hit    = tap.valid && (tap.used <= t_reg);
        promo_wr   = (16'(cnt_reg) < 16'(pend_tot_reg))
                     && (16'(res_tot_reg) < 16'(CACHE_SLOTS));
        enq_wr     = !hit_reg && !pfound_reg && (16'(pend_tot_reg) < 16'(PENDING_SLOTS));
        last_look  = (cnt_reg == CW'(LOOK_LEN - 1));
        last_res   = (cnt_reg == CW'(CACHE_SLOTS - 1));
        last_pend  = (cnt_reg == CW'(PENDING_SLOTS - 1));
        can_out    = !m_tvalid_reg || m_tready;
        if (16'(max_pages_reg) < 16'(CACHE_SLOTS))
        begin
            cap = RCW'(max_pages_reg);
        end
        else
        begin
            cap = RCW'(CACHE_SLOTS);
        end
        ans_try = (cntc_reg >= excess_reg) ? ans_reg : (ans_reg | (32'd1 << bit_reg));
    end

    // tap processing and cell commands
    always_comb
    begin
        res_loop      = tap;
        res_ctl.op    = OP_HOLD;
        res_ctl.wdata = {1'b1, ptap, frame_reg};
        pend_ctl.op   = OP_HOLD;
        pend_ctl.wkey = key_reg;
        case (state_reg)
            S_LOOK:
            begin
                if (res_match && (type_reg == REQ_FEEDBACK))
                begin
                    res_loop.used = frame_reg;
                end
                res_ctl.op  = look_res ? OP_SHIFT : OP_HOLD;
                pend_ctl.op = look_pend ? OP_SHIFT : OP_HOLD;
            end
            S_ENQ:
            begin
                pend_ctl.op = enq_wr ? OP_WRITE : OP_HOLD;
            end
            S_PROMO:
            begin
                res_ctl.op  = promo_wr ? OP_WRITE : OP_HOLD;
                pend_ctl.op = OP_SHIFT;
            end
            S_AGE:
            begin
                if (rm_age)
                begin
                    res_loop.valid = 1'b0;
                end
                res_ctl.op = OP_SHIFT;
            end
            S_COUNT:
            begin
                res_ctl.op = OP_SHIFT;
            end
            S_DROP:
            begin
                if (rm_lt || rm_eq)
                begin
                    res_loop.valid = 1'b0;
                end
                res_ctl.op = OP_SHIFT;
            end
            S_COMPACT:
            begin
                res_ctl.op = cnt_reg[0] ? OP_SWAP_ODD : OP_SWAP_EVEN;
            end
            default:
            begin
                res_ctl.op = OP_HOLD;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        type_next     = type_reg;
        key_next      = key_reg;
        frame_next    = frame_reg;
        thr_next      = thr_reg;
        hit_next      = hit_reg;
        pfound_next   = pfound_reg;
        status_next   = status_reg;
        ev_next       = ev_reg;
        res_tot_next  = res_tot_reg;
        pend_tot_next = pend_tot_reg;
        excess_next   = excess_reg;
        ans_next      = ans_reg;
        t_next        = t_reg;
        bit_next      = bit_reg;
        lt_mode_next  = lt_mode_reg;
        cntc_next     = cntc_reg;
        quota_next    = quota_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    type_next   = s_tuser;
                    frame_next  = s_tdata[75:44];
                    cnt_next    = '0;
                    hit_next    = 1'b0;
                    pfound_next = 1'b0;
                    ev_next     = '0;
                    status_next = ST_DONE;
                    if (s_tuser == REQ_FEEDBACK)
                    begin
                        key_next   = {s_tdata[15:0], s_tdata[19:16], 24'd0};
                        state_next = S_LOOK;
                    end
                    else if (s_tuser == REQ_PAGE)
                    begin
                        key_next   = {s_tdata[15:0], s_tdata[19:16],
                                      s_tdata[31:20], s_tdata[43:32]};
                        state_next = S_LOOK;
                    end
                    else if (s_tuser == REQ_FRAME)
                    begin
                        state_next = S_PROMO;
                    end
                    else if (res_tot_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        thr_next   = thr_of(s_tdata[75:44], s_tdata[107:76]);
                        state_next = S_AGE;
                    end
                end
            end
            S_LOOK:
            begin
                if (look_res && res_match)
                begin
                    hit_next = 1'b1;
                end
                if (look_pend && pend_match)
                begin
                    pfound_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_look)
                begin
                    cnt_next   = '0;
                    state_next = S_ENQ;
                end
            end
            S_ENQ:
            begin
                if (hit_reg)
                begin
                    status_next = ST_HIT;
                end
                else if (pfound_reg)
                begin
                    status_next = ST_PENDING;
                end
                else if (enq_wr)
                begin
                    status_next   = ST_QUEUED;
                    pend_tot_next = pend_tot_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_DROPPED;
                end
                state_next = S_OUT;
            end
            S_PROMO:
            begin
                if (promo_wr)
                begin
                    res_tot_next = res_tot_reg + 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_pend)
                begin
                    cnt_next      = '0;
                    pend_tot_next = '0;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (res_tot_reg > cap)
                begin
                    thr_next   = thr_of(frame_reg, stale_window_reg);
                    state_next = S_AGE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_AGE:
            begin
                if (rm_age)
                begin
                    ev_next      = ev_reg + 1'b1;
                    res_tot_next = res_tot_reg - 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_res)
                begin
                    cnt_next   = '0;
                    state_next = S_EXCESS;
                end
            end
            S_EXCESS:
            begin
                if (res_tot_reg > cap)
                begin
                    excess_next  = res_tot_reg - cap;
                    ev_next      = ev_reg + (res_tot_reg - cap);
                    res_tot_next = cap;
                    ans_next     = '0;
                    bit_next     = 5'd31;
                    lt_mode_next = 1'b0;
                    state_next   = S_SETUP;
                end
                else
                begin
                    state_next = S_COMPACT;
                end
            end
            S_SETUP:
            begin
                // search the age of the last page to drop, one bit a pass
                t_next    = lt_mode_reg ? (ans_reg - 32'd1)
                                        : (ans_reg | ((32'd1 << bit_reg) - 32'd1));
                cntc_next = '0;
                cnt_next  = '0;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (cnt_hit)
                begin
                    cntc_next = cntc_reg + 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_res)
                begin
                    cnt_next   = '0;
                    state_next = S_CNTDONE;
                end
            end
            S_CNTDONE:
            begin
                if (lt_mode_reg)
                begin
                    quota_next = excess_reg - cntc_reg;
                    state_next = S_DROP;
                end
                else
                begin
                    ans_next = ans_try;
                    if (bit_reg == 5'd0)
                    begin
                        if (ans_try == 32'd0)
                        begin
                            quota_next = excess_reg;
                            state_next = S_DROP;
                        end
                        else
                        begin
                            lt_mode_next = 1'b1;
                            state_next   = S_SETUP;
                        end
                    end
                    else
                    begin
                        bit_next   = bit_reg - 5'd1;
                        state_next = S_SETUP;
                    end
                end
            end
            S_DROP:
            begin
                if (rm_eq && !rm_lt)
                begin
                    quota_next = quota_reg - 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_res)
                begin
                    cnt_next   = '0;
                    state_next = S_COMPACT;
                end
            end
            S_COMPACT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_res)
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (can_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            res_tot_reg  <= '0;
            pend_tot_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            res_tot_reg  <= res_tot_next;
            pend_tot_reg <= pend_tot_next;
            if ((state_reg == S_OUT) && can_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign ev_w   = 16'(ev_reg);
    assign res_w  = 16'(res_tot_reg);
    assign pend_w = 16'(pend_tot_reg);

    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        key_reg     <= key_next;
        frame_reg   <= frame_next;
        thr_reg     <= thr_next;
        hit_reg     <= hit_next;
        pfound_reg  <= pfound_next;
        status_reg  <= status_next;
        ev_reg      <= ev_next;
        excess_reg  <= excess_next;
        ans_reg     <= ans_next;
        t_reg       <= t_next;
        bit_reg     <= bit_next;
        lt_mode_reg <= lt_mode_next;
        cntc_reg    <= cntc_next;
        quota_reg   <= quota_next;
        if ((state_reg == S_OUT) && can_out)
        begin
            m_tdata_reg <= {pend_w[5:0], res_w[8:0], ev_w[8:0]};
            m_tuser_reg <= status_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        16'(res_tot_reg) <= 16'(CACHE_SLOTS))
        else $error("resident count above table size");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        16'(pend_tot_reg) <= 16'(PENDING_SLOTS))
        else $error("pending count above queue size");

    a_compact_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (res_q[0].valid == (res_tot_reg != '0)))
        else $error("page chain not compacted at idle");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && can_out) |=> m_tvalid)
        else $error("finished item not presented");

endmodule
